### hw/rtl/bole_pkg.sv
// Shared types and constants for the bounded ordered list engine.
// Used by bole_cell and bounded_ordered_list_engine; depends on nothing.
`default_nettype none
package bole_pkg;

	localparam int CAPACITY = 32;
	localparam int VAL_W = 32;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int OUT_CNT_W = 6;

	typedef enum logic [2:0] {
		REQ_INS_FRONT = 3'd0,
		REQ_INS_END   = 3'd1,
		REQ_INS_AFTER = 3'd2,
		REQ_REM_FRONT = 3'd3,
		REQ_REM_END   = 3'd4,
		REQ_REM_KEY   = 3'd5
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD      = 2'd0,
		CELL_LOAD      = 2'd1,
		CELL_FROM_PREV = 2'd2,
		CELL_FROM_NEXT = 2'd3
	} cell_op_t;

	typedef struct packed {
		req_type_t                req_type;
		logic signed [VAL_W-1:0]  value;
		logic signed [VAL_W-1:0]  key;
	} req_item_t;

	typedef struct packed {
		status_t                  status;
		logic signed [VAL_W-1:0]  removed_value;
		logic [OUT_CNT_W-1:0]     entry_count;
	} rsp_item_t;

endpackage
`default_nettype wire

### hw/rtl/bole_cell.sv
// One storage cell of the list chain: holds an entry and compares it with the key.
// Depends on bole_pkg for the cell operation type and value width.
`default_nettype none
module bole_cell (
	input  wire logic                             clk,
	input  wire bole_pkg::cell_op_t               op,
	input  wire logic signed [bole_pkg::VAL_W-1:0] prev_value,
	input  wire logic signed [bole_pkg::VAL_W-1:0] next_value,
	input  wire logic signed [bole_pkg::VAL_W-1:0] new_value,
	input  wire logic signed [bole_pkg::VAL_W-1:0] key,
	output logic signed [bole_pkg::VAL_W-1:0]      value,
	output logic                                   match
);

	logic signed [bole_pkg::VAL_W-1:0] value_q;

	always_ff @(posedge clk) begin
		unique case (op)
			bole_pkg::CELL_HOLD:      value_q <= value_q;
			bole_pkg::CELL_LOAD:      value_q <= new_value;
			bole_pkg::CELL_FROM_PREV: value_q <= prev_value;
			bole_pkg::CELL_FROM_NEXT: value_q <= next_value;
		endcase
	end

	assign value = value_q;
	assign match = (value_q == key);

endmodule
`default_nettype wire

### hw/rtl/bounded_ordered_list_engine.sv
// A request transfer loads req_s1, match_s1 and busy_q; the list update and response
// are then registered together. No request is taken while busy or a response waits;
// the cell compare is registered on the accepting edge; cells from pos up then change.
// Reset clears the entry count and the handshake state; cell contents are left as
// they are and only entries below the count are ever read.
// Top level of the bounded ordered list engine; depends on bole_pkg and bole_cell.
`default_nettype none
module bounded_ordered_list_engine (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire bole_pkg::req_item_t req,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	output bole_pkg::rsp_item_t      rsp
);

	localparam int CAP = bole_pkg::CAPACITY;
	localparam int CW = bole_pkg::CNT_W;
	localparam int VW = bole_pkg::VAL_W;

	logic                      busy_q;
	logic                      rsp_valid_q;
	bole_pkg::rsp_item_t       rsp_q;
	logic [CW-1:0]             count_q;
	bole_pkg::req_item_t       req_s1;
	logic [CAP-1:0]            match_s1;

	logic                      accept_in;
	logic [CAP:0]              thermo;
	logic [CAP-1:0]            valid_vec;
	logic [CAP-1:0]            match_vec;
	logic signed [VW-1:0]      cell_value [CAP];
	bole_pkg::cell_op_t        cell_op [CAP];

	logic [CAP-1:0]            first;
	logic                      found;
	logic                      full;
	logic                      empty;
	logic [CAP:0]              end_pos;
	logic [CW-1:0]             last_idx;
	logic [CAP-1:0]            last_pos;
	logic [CAP-1:0]            pos;
	logic [CAP-1:0]            ge_mask;
	logic                      do_ins;
	logic                      do_rem;
	bole_pkg::status_t         status;
	logic signed [VW-1:0]      removed;
	logic [CW-1:0]             next_count;

	assign accept_in = req_valid && req_ready;
	assign req_ready = !busy_q && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	assign thermo = ((CAP+1)'(1) << count_q) - (CAP+1)'(1);
	assign valid_vec = thermo[CAP-1:0];

	genvar gi;
	generate
		for (gi = 0; gi < CAP; gi++) begin : g_cell
			logic signed [VW-1:0] prev_v;
			logic signed [VW-1:0] next_v;
			if (gi == 0) begin : g_first
				assign prev_v = '0;
			end else begin : g_mid
				assign prev_v = cell_value[gi-1];
			end
			if (gi == CAP - 1) begin : g_last
				assign next_v = '0;
			end else begin : g_inner
				assign next_v = cell_value[gi+1];
			end
			bole_cell u_cell (
				.clk        (clk),
				.op         (cell_op[gi]),
				.prev_value (prev_v),
				.next_value (next_v),
				.new_value  (req_s1.value),
				.key        (req.key),
				.value      (cell_value[gi]),
				.match      (match_vec[gi])
			);
		end
	endgenerate

	always_comb begin
		first = match_s1 & (~match_s1 + CAP'(1));
		found = |match_s1;
		full = (count_q == CW'(CAP));
		empty = (count_q == '0);
		end_pos = (CAP+1)'(1) << count_q;
		last_idx = count_q - CW'(1);
		last_pos = CAP'(1) << last_idx[$clog2(CAP)-1:0];
		pos = '0;
		do_ins = 1'b0;
		do_rem = 1'b0;
		status = bole_pkg::ST_OK;
		unique case (req_s1.req_type)
			bole_pkg::REQ_INS_FRONT, bole_pkg::REQ_INS_END, bole_pkg::REQ_INS_AFTER: begin
				if (full) begin
					status = bole_pkg::ST_FULL;
				end else if (req_s1.req_type == bole_pkg::REQ_INS_FRONT) begin
					pos = CAP'(1);
					do_ins = 1'b1;
				end else if (req_s1.req_type == bole_pkg::REQ_INS_END) begin
					pos = end_pos[CAP-1:0];
					do_ins = 1'b1;
				end else if (!found) begin
					status = bole_pkg::ST_NOT_FOUND;
				end else begin
					pos = first << 1;
					do_ins = 1'b1;
				end
			end
			bole_pkg::REQ_REM_FRONT, bole_pkg::REQ_REM_END, bole_pkg::REQ_REM_KEY: begin
				if (empty) begin
					status = bole_pkg::ST_EMPTY;
				end else if (req_s1.req_type == bole_pkg::REQ_REM_FRONT) begin
					pos = CAP'(1);
					do_rem = 1'b1;
				end else if (req_s1.req_type == bole_pkg::REQ_REM_END) begin
					pos = last_pos;
					do_rem = 1'b1;
				end else if (!found) begin
					status = bole_pkg::ST_NOT_FOUND;
				end else begin
					pos = first;
					do_rem = 1'b1;
				end
			end
			default: begin
				status = bole_pkg::ST_OK;
			end
		endcase
		ge_mask = ~(pos - CAP'(1));
	end

	always_comb begin
		removed = '0;
		for (int i = 0; i < CAP; i++) begin
			removed = removed | (cell_value[i] & {VW{pos[i] & do_rem}});
		end
	end

	always_comb begin
		for (int i = 0; i < CAP; i++) begin
			cell_op[i] = bole_pkg::CELL_HOLD;
			if (busy_q && do_ins) begin
				if (pos[i]) begin
					cell_op[i] = bole_pkg::CELL_LOAD;
				end else if (ge_mask[i]) begin
					cell_op[i] = bole_pkg::CELL_FROM_PREV;
				end
			end else if (busy_q && do_rem && ge_mask[i]) begin
				cell_op[i] = bole_pkg::CELL_FROM_NEXT;
			end
		end
	end

	always_comb begin
		next_count = count_q;
		if (do_ins) begin
			next_count = count_q + CW'(1);
		end else if (do_rem) begin
			next_count = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			count_q <= '0;
		end else begin
			busy_q <= accept_in;
			if (busy_q) begin
				rsp_valid_q <= 1'b1;
				count_q <= next_count;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			req_s1 <= req;
			match_s1 <= match_vec & valid_vec;
		end
		if (busy_q) begin
			rsp_q.status <= status;
			rsp_q.removed_value <= removed;
			rsp_q.entry_count <= bole_pkg::OUT_CNT_W'(next_count);
		end
	end

	a_rsp_follows_req: assert property (@(posedge clk) disable iff (!arst_n)
		accept_in |=> ##1 rsp_valid)
		else $error("response did not follow request");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAP))
		else $error("entry count above capacity");

	a_match_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> ((match_s1 & ~valid_vec) == '0))
		else $error("match outside held entries");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == bole_pkg::ST_FULL) |->
			(rsp.entry_count == bole_pkg::OUT_CNT_W'(CAP)))
		else $error("full status with spare room");

endmodule
`default_nettype wire

### bench/tb_bounded_ordered_list_engine.sv
// Self-checking testbench for bounded_ordered_list_engine: directed and random list requests,
// checked against a queue-based predictor of the ordered list under random handshake stalls.
// Depends on bole_pkg and the engine RTL only.
`default_nettype none
module tb_bounded_ordered_list_engine;

	localparam int N_RANDOM = 600;
	localparam int HOLD_AT = 150;
	localparam int HOLD_LEN = 200;
	localparam int DRAIN_AT = 260;
	localparam int QUIET_LO = 350;
	localparam int QUIET_HI = 470;
	localparam int STALL_LIMIT = 2000;
	localparam logic [2:0] REQ_SPARE_6 = 3'd6;
	localparam logic [2:0] REQ_SPARE_7 = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	bole_pkg::req_item_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	bole_pkg::rsp_item_t rsp;

	bole_pkg::req_item_t pending_q[$];
	bole_pkg::rsp_item_t expected_q[$];
	logic signed [bole_pkg::VAL_W-1:0] list_q[$];
	int sent_count = 0;
	int rsp_seen = 0;
	int err_count = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int stall_cycles = 0;

	bounded_ordered_list_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int find_key(logic signed [bole_pkg::VAL_W-1:0] k);
		for (int i = 0; i < list_q.size(); i++) begin
			if (list_q[i] == k)
				return i;
		end
		return -1;
	endfunction

	function automatic bole_pkg::rsp_item_t apply_request(bole_pkg::req_item_t r);
		bole_pkg::rsp_item_t e;
		int pos;
		e.status = bole_pkg::ST_OK;
		e.removed_value = '0;
		case (r.req_type)
		bole_pkg::REQ_INS_FRONT, bole_pkg::REQ_INS_END, bole_pkg::REQ_INS_AFTER: begin
			if (list_q.size() >= bole_pkg::CAPACITY) begin
				e.status = bole_pkg::ST_FULL;
			end else if (r.req_type == bole_pkg::REQ_INS_FRONT) begin
				list_q.push_front(r.value);
			end else if (r.req_type == bole_pkg::REQ_INS_END) begin
				list_q.push_back(r.value);
			end else begin
				pos = find_key(r.key);
				if (pos < 0)
					e.status = bole_pkg::ST_NOT_FOUND;
				else
					list_q.insert(pos + 1, r.value);
			end
		end
		bole_pkg::REQ_REM_FRONT, bole_pkg::REQ_REM_END, bole_pkg::REQ_REM_KEY: begin
			if (list_q.size() == 0) begin
				e.status = bole_pkg::ST_EMPTY;
			end else if (r.req_type == bole_pkg::REQ_REM_FRONT) begin
				e.removed_value = list_q.pop_front();
			end else if (r.req_type == bole_pkg::REQ_REM_END) begin
				e.removed_value = list_q.pop_back();
			end else begin
				pos = find_key(r.key);
				if (pos < 0) begin
					e.status = bole_pkg::ST_NOT_FOUND;
				end else begin
					e.removed_value = list_q[pos];
					list_q.delete(pos);
				end
			end
		end
		default: begin
		end
		endcase
		e.entry_count = bole_pkg::OUT_CNT_W'(list_q.size());
		return e;
	endfunction

	function automatic logic signed [bole_pkg::VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
		0, 1, 2, 3, 4: return $urandom_range(0, 15) - 8;
		5: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
		default: return $urandom();
		endcase
	endfunction

	function automatic bole_pkg::req_item_t make_req(logic [2:0] kind,
			logic signed [bole_pkg::VAL_W-1:0] v, logic signed [bole_pkg::VAL_W-1:0] k);
		bole_pkg::req_item_t r;
		r.req_type = bole_pkg::req_type_t'(kind);
		r.value = v;
		r.key = k;
		return r;
	endfunction

	// Driver: the predictor is advanced on every accepted request transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && req_ready) begin
				expected_q.push_back(apply_request(req));
				sent_count = sent_count + 1;
			end
			if (!req_valid || req_ready) begin
				if (pending_q.size() != 0
						&& !(sent_count == DRAIN_AT && expected_q.size() != 0)
						&& ((sent_count >= QUIET_LO && sent_count < QUIET_HI)
						|| $urandom_range(0, 99) >= 10)) begin
					req_valid <= 1'b1;
					req <= pending_q.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compares each response transfer with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected response transfer: status %0d %s %0d %s %0d",
						rsp.status, "removed_value", rsp.removed_value,
						"entry_count", rsp.entry_count);
					err_count = err_count + 1;
				end else begin
					automatic bole_pkg::rsp_item_t e = expected_q.pop_front();
					if (rsp.status !== e.status) begin
						$error("status: expected %0d, actual %0d", e.status, rsp.status);
						err_count = err_count + 1;
					end
					if (rsp.removed_value !== e.removed_value) begin
						$error("removed_value: expected %0d, actual %0d",
							e.removed_value, rsp.removed_value);
						err_count = err_count + 1;
					end
					if (rsp.entry_count !== e.entry_count) begin
						$error("entry_count: expected %0d, actual %0d",
							e.entry_count, rsp.entry_count);
						err_count = err_count + 1;
					end
				end
				rsp_seen = rsp_seen + 1;
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				rsp_ready <= 1'b0;
			end else if (rsp_seen >= HOLD_AT && !hold_done) begin
				hold_left <= HOLD_LEN;
				hold_done <= 1'b1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= (rsp_seen >= QUIET_LO && rsp_seen < QUIET_HI)
					|| $urandom_range(0, 99) >= 10;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles == STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		bole_pkg::req_item_t item;
		bole_pkg::req_type_t ins_kind[3];
		bole_pkg::req_type_t rem_kind[3];
		int target;
		int phase;
		int ins_pct;
		int roll;
		ins_kind = '{bole_pkg::REQ_INS_FRONT, bole_pkg::REQ_INS_END, bole_pkg::REQ_INS_AFTER};
		rem_kind = '{bole_pkg::REQ_REM_FRONT, bole_pkg::REQ_REM_END, bole_pkg::REQ_REM_KEY};
		phase = 0;

		pending_q.push_back(make_req(bole_pkg::REQ_REM_FRONT, 32'sh5a5a5a5a, 0));
		pending_q.push_back(make_req(bole_pkg::REQ_REM_END, 0, 0));
		pending_q.push_back(make_req(bole_pkg::REQ_REM_KEY, 0, 0));
		pending_q.push_back(make_req(bole_pkg::REQ_INS_AFTER, 3, 0));
		pending_q.push_back(make_req(bole_pkg::REQ_INS_FRONT, 32'sh7fffffff, 0));
		pending_q.push_back(make_req(bole_pkg::REQ_INS_END, 32'sh80000000, 0));
		pending_q.push_back(make_req(bole_pkg::REQ_INS_FRONT, 0, 0));
		pending_q.push_back(make_req(bole_pkg::REQ_INS_END, -1, 0));
		pending_q.push_back(make_req(bole_pkg::REQ_INS_AFTER, 5, 0));
		pending_q.push_back(make_req(bole_pkg::REQ_INS_AFTER, 9, 32'sh12345678));
		pending_q.push_back(make_req(bole_pkg::REQ_INS_END, 5, 0));
		pending_q.push_back(make_req(bole_pkg::REQ_INS_AFTER, 7, 5));
		pending_q.push_back(make_req(bole_pkg::REQ_REM_KEY, 0, 5));
		pending_q.push_back(make_req(bole_pkg::REQ_REM_KEY, 0, 42));
		pending_q.push_back(make_req(REQ_SPARE_6, 32'shffffffff, 32'shffffffff));
		pending_q.push_back(make_req(REQ_SPARE_7, 32'sh2468ace0, 5));
		pending_q.push_back(make_req(bole_pkg::REQ_REM_FRONT, 0, 0));
		pending_q.push_back(make_req(bole_pkg::REQ_REM_END, 0, 0));
		pending_q.push_back(make_req(bole_pkg::REQ_REM_KEY, 0, 32'sh80000000));
		pending_q.push_back(make_req(bole_pkg::REQ_REM_KEY, 0, -1));
		pending_q.push_back(make_req(bole_pkg::REQ_REM_FRONT, 0, 0));
		pending_q.push_back(make_req(bole_pkg::REQ_REM_END, 0, 0));
		pending_q.push_back(make_req(bole_pkg::REQ_REM_END, 0, 0));
		pending_q.push_back(make_req(bole_pkg::REQ_INS_AFTER, 1, 32'sh7fffffff));

		// Segments alternate between filling, draining and a balanced mix, so that the
		// list repeatedly reaches both full and empty with small values that collide often.
		target = pending_q.size() + N_RANDOM;
		while (pending_q.size() < target) begin
			ins_pct = (phase == 0) ? 90 : (phase == 1) ? 10 : 50;
			phase = (phase + 1) % 3;
			repeat ($urandom_range(40, 80)) begin
				roll = $urandom_range(0, 99);
				if (roll < 3)
					item.req_type = bole_pkg::req_type_t'(roll[0] ? REQ_SPARE_7 : REQ_SPARE_6);
				else if ($urandom_range(0, 99) < ins_pct)
					item.req_type = ins_kind[$urandom_range(0, 2)];
				else
					item.req_type = rem_kind[$urandom_range(0, 2)];
				item.value = pick_value();
				item.key = pick_value();
				pending_q.push_back(item);
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_q.size() != 0 || req_valid || expected_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire
